### hw/rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types, round constants, initial values and mixing functions for the
// SHA-512 / SHA-384 hash engine.
// ----------------------------------------------------------------------------
package sha512_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       is_last;
  } msg_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic        last_word;
  } dig_item_t;

  // Working variables, index 0 is a, index 7 is h
  typedef logic [7:0][63:0] vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_CLOAD,
    ST_ROUND,
    ST_CUPD,
    ST_DREQ,
    ST_DLOAD,
    ST_DOUT
  } state_t;

  localparam int unsigned ROUNDS = 80;

  localparam logic [63:0] K_TAB [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] IV_512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [63:0] IV_384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  function automatic logic [63:0] iv_word(input logic mode, input logic [2:0] idx);
    return mode ? IV_384[idx] : IV_512[idx];
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned s);
    return (x >> s) | (x << (64 - s));
  endfunction

  function automatic logic [63:0] big_sig0(input logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sig1(input logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] sml_sig0(input logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] sml_sig1(input logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

### hw/rtl/sha512_ram.sv
// ----------------------------------------------------------------------------
// sha512_ram
// Generic one-write, one-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module sha512_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/sha512_round.sv
// ----------------------------------------------------------------------------
// sha512_round
// One SHA-512 compression round on the working variables, given the
// pre-added sum of h, the round constant and the schedule word.
// ----------------------------------------------------------------------------
module sha512_round (
  input  sha512_pkg::vec_t v_in,
  input  logic [63:0]      hkw,
  output sha512_pkg::vec_t v_out
);

  logic [63:0] t1;
  logic [63:0] t2;
  logic [63:0] ch;
  logic [63:0] maj;

  // Mix the round
  always_comb begin
    ch  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t1  = hkw + sha512_pkg::big_sig1(v_in[4]) + ch;
    t2  = sha512_pkg::big_sig0(v_in[0]) + maj;
    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end

endmodule

### hw/rtl/sha512_sha384_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha512_sha384_hash_engine_unit
// Streaming SHA-512 / SHA-384 engine with block and chain state in RAM.
// ----------------------------------------------------------------------------
// Message bytes are taken one item per cycle while a block fills. The item
// that completes a 128-byte block stalls the input while the engine reads
// the chain value, runs 80 rounds (the schedule RAM is read at four places
// per round through two read ports) and adds and writes the chain value
// back. The final item starts padding, which inserts one byte per cycle up
// to the end of the block (plus a second block when fewer than 17 bytes
// remain), then 8 or 6 digest words leave one at a time, each held until
// taken. The mode register reloads the initial values as long as no block
// of the current message has been compressed.
module sha512_sha384_hash_engine_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   msg_valid,
  output logic                   msg_ready,
  input  sha512_pkg::msg_item_t  msg,
  output logic                   dig_valid,
  input  logic                   dig_ready,
  output sha512_pkg::dig_item_t  dig,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  sha512_pkg::state_t state, state_next;

  logic        mode;
  logic [6:0]  fill;
  logic [60:0] msg_cnt;
  logic        started;
  logic        in_pad;
  logic        fin;
  logic        marker_done;
  logic        len_blk;
  logic [3:0]  cnt;
  logic [6:0]  rnd;
  logic [1:0]  ph;
  logic [2:0]  dk;

  logic [63:0] acc;
  logic [63:0] wa;
  logic [63:0] wb;
  logic [63:0] hkw;
  logic [63:0] wsch;
  logic [2:0]  ridx;
  sha512_pkg::vec_t v;
  sha512_pkg::vec_t v_rnd;

  logic        ins_en;
  logic [7:0]  ins_byte;
  logic [7:0]  pad_byte;
  logic [63:0] len_bits;
  logic [63:0] len_sh;
  logic        cfg_wr;
  logic        dig_last;

  logic        w_we;
  logic [3:0]  w_waddr;
  logic [63:0] w_wdata;
  logic [3:0]  w_raddr_a;
  logic [3:0]  w_raddr_b;
  logic [63:0] qa;
  logic [63:0] qb;

  logic        c_we;
  logic [2:0]  c_waddr;
  logic [63:0] c_wdata;
  logic [2:0]  c_raddr;
  logic [63:0] c_q;
  logic [63:0] rd;

  // APB register
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = {31'd0, mode};

  // Padding byte: marker, zero fill, then the 128-bit length
  assign len_bits = {msg_cnt, 3'b000};
  assign len_sh   = len_bits >> {3'd7 - fill[2:0], 3'b000};
  always_comb begin
    if (!marker_done) begin
      pad_byte = 8'h80;
    end else if (len_blk && fill[6:3] == 4'd15) begin
      pad_byte = len_sh[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign dig_last = (dk == (mode ? 3'd5 : 3'd7));

  // Next state and handshake
  always_comb begin
    state_next = state;
    ins_en     = 1'b0;
    ins_byte   = msg.msg_byte;
    msg_ready  = 1'b0;
    dig_valid  = 1'b0;
    unique case (state)
      sha512_pkg::ST_IDLE: begin
        msg_ready = 1'b1;
        if (msg_valid) begin
          ins_en = msg.has_byte;
          if (msg.has_byte && fill == 7'd127) begin
            state_next = sha512_pkg::ST_CLOAD;
          end else if (msg.is_last) begin
            state_next = sha512_pkg::ST_PAD;
          end
        end
      end
      sha512_pkg::ST_PAD: begin
        ins_en   = 1'b1;
        ins_byte = pad_byte;
        if (fill == 7'd127) begin
          state_next = sha512_pkg::ST_CLOAD;
        end
      end
      sha512_pkg::ST_CLOAD: begin
        if (cnt == 4'd8) begin
          state_next = sha512_pkg::ST_ROUND;
        end
      end
      sha512_pkg::ST_ROUND: begin
        if (ph == 2'd3 && rnd == 7'(sha512_pkg::ROUNDS - 1)) begin
          state_next = sha512_pkg::ST_CUPD;
        end
      end
      sha512_pkg::ST_CUPD: begin
        if (cnt == 4'd8) begin
          if (fin) begin
            state_next = sha512_pkg::ST_DREQ;
          end else if (in_pad) begin
            state_next = sha512_pkg::ST_PAD;
          end else begin
            state_next = sha512_pkg::ST_IDLE;
          end
        end
      end
      sha512_pkg::ST_DREQ: begin
        state_next = sha512_pkg::ST_DLOAD;
      end
      sha512_pkg::ST_DLOAD: begin
        state_next = sha512_pkg::ST_DOUT;
      end
      sha512_pkg::ST_DOUT: begin
        dig_valid = 1'b1;
        if (dig_ready) begin
          state_next = dig.last_word ? sha512_pkg::ST_IDLE : sha512_pkg::ST_DREQ;
        end
      end
      default: begin
        state_next = sha512_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha512_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= 1'b0;
      fill        <= '0;
      msg_cnt     <= '0;
      started     <= 1'b0;
      in_pad      <= 1'b0;
      fin         <= 1'b0;
      marker_done <= 1'b0;
      len_blk     <= 1'b0;
      cnt         <= '0;
      rnd         <= '0;
      ph          <= '0;
      dk          <= '0;
    end else begin
      if (cfg_wr && !paddr[2]) begin
        mode <= pwdata[0];
      end
      if (ins_en) begin
        fill <= fill + 7'd1;
      end
      if (state == sha512_pkg::ST_IDLE && msg_valid) begin
        if (msg.has_byte) begin
          msg_cnt <= msg_cnt + 61'd1;
        end
        in_pad      <= msg.is_last;
        marker_done <= 1'b0;
        fin         <= 1'b0;
      end
      if (state == sha512_pkg::ST_PAD) begin
        marker_done <= 1'b1;
        // Block wraps: length goes into this one or the next
        if (fill == 7'd127) begin
          fin     <= marker_done && len_blk;
          len_blk <= 1'b1;
        end else if (!marker_done) begin
          len_blk <= (fill[6:4] != 3'b111);
        end
      end
      if (state == sha512_pkg::ST_CLOAD || state == sha512_pkg::ST_CUPD) begin
        cnt <= (cnt == 4'd8) ? 4'd0 : cnt + 4'd1;
      end
      if (state == sha512_pkg::ST_CUPD && cnt == 4'd8) begin
        started <= 1'b1;
      end
      if (state == sha512_pkg::ST_ROUND) begin
        ph <= ph + 2'd1;
        if (ph == 2'd3) begin
          rnd <= (rnd == 7'(sha512_pkg::ROUNDS - 1)) ? 7'd0 : rnd + 7'd1;
        end
      end
      // Advance the digest word, or close the message
      if (state == sha512_pkg::ST_DOUT && dig_ready) begin
        if (dig.last_word) begin
          dk      <= '0;
          started <= 1'b0;
          msg_cnt <= '0;
          in_pad  <= 1'b0;
          fin     <= 1'b0;
        end else begin
          dk <= dk + 3'd1;
        end
      end
    end
  end

  // Schedule RAM ports: byte packing writes and schedule write back
  always_comb begin
    w_we    = 1'b0;
    w_waddr = fill[6:3];
    w_wdata = {acc[55:0], ins_byte};
    if (ins_en && fill[2:0] == 3'd7) begin
      w_we = 1'b1;
    end else if (state == sha512_pkg::ST_ROUND && ph == 2'd2 && rnd >= 7'd16) begin
      w_we    = 1'b1;
      w_waddr = rnd[3:0];
      w_wdata = wsch;
    end
    if (ph == 2'd0) begin
      w_raddr_a = rnd[3:0];
      w_raddr_b = rnd[3:0] + 4'd1;
    end else begin
      w_raddr_a = rnd[3:0] + 4'd9;
      w_raddr_b = rnd[3:0] + 4'd14;
    end
  end

  assign wsch = (rnd < 7'd16) ? wa :
                wa + sha512_pkg::sml_sig0(wb) + qa + sha512_pkg::sml_sig1(qb);

  // Chain RAM ports; a fresh message reads the initial values
  always_comb begin
    c_raddr = (state == sha512_pkg::ST_DREQ) ? dk : cnt[2:0];
    c_we    = (state == sha512_pkg::ST_CUPD) && (cnt != 4'd0);
    c_waddr = cnt[2:0] - 3'd1;
    c_wdata = rd + v[0];
  end

  assign rd = started ? c_q : sha512_pkg::iv_word(mode, ridx);

  // Datapath registers
  always_ff @(posedge clk) begin
    ridx <= c_raddr;
    if (ins_en) begin
      acc <= {acc[55:0], ins_byte};
    end
    if (state == sha512_pkg::ST_CLOAD && cnt != 4'd0) begin
      v <= {rd, v[7:1]};
    end
    if (state == sha512_pkg::ST_ROUND) begin
      if (ph == 2'd1) begin
        wa <= qa;
        wb <= qb;
      end
      if (ph == 2'd2) begin
        hkw <= v[7] + sha512_pkg::K_TAB[rnd] + wsch;
      end
      if (ph == 2'd3) begin
        v <= v_rnd;
      end
    end
    if (state == sha512_pkg::ST_CUPD && cnt != 4'd0) begin
      v <= {v[0], v[7:1]};
    end
    if (state == sha512_pkg::ST_DLOAD) begin
      dig.digest_word <= rd;
      dig.last_word   <= dig_last;
    end
  end

  // Two copies of the schedule RAM give two read ports
  sha512_ram #(.WIDTH(64), .DEPTH(16)) u_wram_a (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr_a),
    .rdata (qa)
  );

  sha512_ram #(.WIDTH(64), .DEPTH(16)) u_wram_b (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr_b),
    .rdata (qb)
  );

  sha512_ram #(.WIDTH(64), .DEPTH(8)) u_cram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_q)
  );

  sha512_round u_round (
    .v_in  (v),
    .hkw   (hkw),
    .v_out (v_rnd)
  );

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && dig_valid))
    else $error("input taken while a digest word is pending");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == sha512_pkg::ST_ROUND && ph == 2'd3 && rnd == 7'(sha512_pkg::ROUNDS - 1))
    |=> state == sha512_pkg::ST_CUPD)
    else $error("last round did not go to chain update");

  a_msg_close: assert property (@(posedge clk) disable iff (rst)
    (dig_valid && dig_ready && dig.last_word) |=> (!started && msg_cnt == 61'd0))
    else $error("message state not cleared after digest");

  a_started: assert property (@(posedge clk) disable iff (rst)
    (state == sha512_pkg::ST_CUPD && cnt == 4'd8) |=> started)
    else $error("chain not marked after compression");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives message bytes into the SHA-512 / SHA-384 engine, writes the mode
// register between messages and within one, and checks every digest word
// against a behavioral hash model kept in the testbench.
// ----------------------------------------------------------------------------

class digest_scoreboard;
  bit [63:0] chain [8];
  bit [63:0] blk [16];
  int unsigned fill;
  bit [60:0] nbytes;
  bit started;
  bit mode;
  bit [64:0] pending [$];
  int unsigned errors;
  int unsigned words_seen;
  int unsigned messages;

  static function bit [63:0] rr(bit [63:0] v, int unsigned s);
    return (v >> s) | (v << (64 - s));
  endfunction

  function void load_iv();
    for (int i = 0; i < 8; i++) begin
      chain[i] = mode ? sha512_pkg::IV_384[i] : sha512_pkg::IV_512[i];
    end
  endfunction

  function void clear();
    mode = 0;
    load_iv();
    for (int i = 0; i < 16; i++) blk[i] = '0;
    fill = 0;
    nbytes = '0;
    started = 0;
  endfunction

  function void set_mode(bit m);
    mode = m;
    if (!started) load_iv();
  endfunction

  function void put(int unsigned pos, bit [7:0] b);
    int unsigned wi;
    int unsigned sh;
    wi = (pos >> 3) & 15;
    sh = 56 - 8 * (pos & 7);
    if ((pos & 7) == 0) blk[wi] = {b, 56'h0};
    else blk[wi] |= 64'(b) << sh;
  endfunction

  function void compress();
    bit [63:0] w [80];
    bit [63:0] v [8];
    bit [63:0] t1;
    bit [63:0] t2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 80; j++) begin
      w[j] = w[j-16] + w[j-7]
           + (rr(w[j-15], 1) ^ rr(w[j-15], 8) ^ (w[j-15] >> 7))
           + (rr(w[j-2], 19) ^ rr(w[j-2], 61) ^ (w[j-2] >> 6));
    end
    for (int j = 0; j < 8; j++) v[j] = chain[j];
    for (int j = 0; j < 80; j++) begin
      t1 = v[7] + (rr(v[4], 14) ^ rr(v[4], 18) ^ rr(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::K_TAB[j] + w[j];
      t2 = (rr(v[0], 28) ^ rr(v[0], 34) ^ rr(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
    started = 1;
  endfunction

  // Note one accepted input item and queue any digest words it causes
  function void note_item(sha512_pkg::msg_item_t it);
    int unsigned n;
    if (it.has_byte) begin
      put(fill, it.msg_byte);
      fill++;
      nbytes++;
      if (fill >= 128) begin
        compress();
        fill = 0;
      end
    end
    if (!it.is_last) return;
    put(fill, 8'h80);
    for (int p = fill + 1; p < 128; p++) put(p, 8'h00);
    if (fill >= 112) begin
      compress();
      for (int i = 0; i < 16; i++) blk[i] = '0;
    end
    blk[14] = '0;
    blk[15] = {nbytes, 3'b000};
    compress();
    n = mode ? 6 : 8;
    for (int k = 0; k < n; k++) pending.push_back({chain[k], k + 1 == n});
    messages++;
    load_iv();
    fill = 0;
    nbytes = '0;
    started = 0;
  endfunction

  function void report(string what, bit [63:0] got, bit [63:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h", what, got, want);
  endfunction

  // Compare one accepted digest word with the oldest expectation
  function void check_word(sha512_pkg::dig_item_t d);
    bit [64:0] e;
    words_seen++;
    if (pending.size() == 0) begin
      report("unexpected word", d.digest_word, '0);
      return;
    end
    e = pending.pop_front();
    if (d.digest_word !== e[64:1]) report("digest_word", d.digest_word, e[64:1]);
    if (d.last_word !== e[0]) report("last_word", 64'(d.last_word), 64'(e[0]));
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic msg_valid = 0;
  logic msg_ready;
  sha512_pkg::msg_item_t msg = '0;
  logic dig_valid;
  logic dig_ready = 0;
  sha512_pkg::dig_item_t dig;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam logic [2:0] ADDR_MODE = 3'd0;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  digest_scoreboard sb = new();
  bit calm;
  int unsigned idle_cycles;
  int unsigned items_sent;

  sha512_sha384_hash_engine_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Check digest words and apply random back-pressure
  always @(posedge clk) begin
    if (!rst) begin
      if (dig_valid && dig_ready) sb.check_word(dig);
      dig_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Count cycles without any accepted item
  always @(posedge clk) begin
    if ((msg_valid && msg_ready) || (dig_valid && dig_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("sha512_sha384_hash_engine_unit regression: fail");
      $finish;
    end
  end

  // Hold valid until the item is taken; the next caller drops or reloads it
  task automatic send_item(bit [7:0] b, bit hb, bit last);
    sha512_pkg::msg_item_t it;
    while (!calm && $urandom_range(99) < 6) begin
      msg_valid <= 0;
      @(posedge clk);
    end
    it.msg_byte = b;
    it.has_byte = hb;
    it.is_last = last;
    msg_valid <= 1;
    msg <= it;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic drain();
    msg_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mode(bit [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_MODE; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_mode(val[0]);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_message(int unsigned len, bit pattern);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 0, 0);
      send_item(pattern ? 8'(i) : 8'($urandom), 1, (i == len - 1) && !pattern);
    end
    if (pattern || len == 0) send_item(8'($urandom), 0, 1);
  endtask

  initial begin
    sb.clear();
    calm = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty messages, byte extremes, idle items
    send_item(8'hFF, 0, 1);
    send_item(8'h00, 0, 0);
    send_item(8'h00, 1, 0);
    send_item(8'hFF, 1, 1);
    drain();
    write_mode(32'hFFFF_FFFF);
    send_item(8'hA5, 0, 1);
    send_message(3, 0);
    drain();
    write_mode(32'h0000_0000);
    // Length spills into a second block
    send_message(112, 0);
    drain();

    // Mode change after a block has been compressed stays out of the chain
    write_mode(32'h1);
    calm = 1;
    for (int i = 0; i < 128; i++) send_item(8'($urandom), 1, 0);
    calm = 0;
    drain();
    write_mode(32'h0);
    send_item(8'h5A, 1, 1);
    drain();

    // Random short messages, mode changed between them
    while (items_sent < 280) begin
      if ($urandom_range(3) == 0) begin
        drain();
        write_mode($urandom);
      end
      send_message($urandom_range(20), 0);
    end
    drain();

    $display("covered %0d items, %0d messages, %0d digest words, both modes",
             items_sent, sb.messages, sb.words_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sha512_sha384_hash_engine_unit regression: pass");
    end else begin
      $display("sha512_sha384_hash_engine_unit regression: fail");
    end
    $finish;
  end
endmodule

### filelist.f
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_ram.sv
hw/rtl/sha512_round.sv
hw/rtl/sha512_sha384_hash_engine_unit.sv
tb/testbench.sv
